// File: design/aes_block_cipher_core_macros.svh
// Assertion macros used by the cipher core module.
`ifndef AES_BLOCK_CIPHER_CORE_MACROS_SVH
`define AES_BLOCK_CIPHER_CORE_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define AES_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);
`endif

// File: design/aes_pkg.sv
// -----------------------------------------------------------------------------
// AES package
// Shared constants, tables and byte-level functions for the AES core.
// -----------------------------------------------------------------------------
package aes_pkg;

    localparam int RoundKeyWords = 60;
    localparam int RkAddrW = $clog2(RoundKeyWords);

    localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [2:0] CFG_KEY_W0 = 3'd1;
    localparam logic [2:0] CFG_KEY_W1 = 3'd2;
    localparam logic [2:0] CFG_KEY_W2 = 3'd3;
    localparam logic [2:0] CFG_KEY_W3 = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: design/aes_block_cipher_core.sv
// -----------------------------------------------------------------------------
// AES block cipher core
// ECB AES-128/192/256 with an iterative round unit and a round-key store.
// -----------------------------------------------------------------------------
//  channel | ports                    | direction
//  input   | s_valid/s_ready, payload | in
//  result  | m_valid/m_ready, payload | out
//  config  | cfg_we, cfg_index, data  | in
// After acceptance, each of the Nr+1 rounds of a block fetches its four key words
// from the store and then applies them to the state.
// The first block after a key change first expands the key, one word a cycle.
// Reset clears control state; the store needs no clear.
// s_ready is low while a block is in work or its result waits on m_ready, and it
// rises the cycle after the result beat is taken.
// -----------------------------------------------------------------------------
module aes_block_cipher_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_action,
    input  logic [63:0]  s_data_hi,
    input  logic [63:0]  s_data_lo,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  m_out_hi,
    output logic [63:0]  m_out_lo
);
    import aes_pkg::*;
    `include "aes_block_cipher_core_macros.svh"

    typedef enum logic [2:0] {ST_IDLE, ST_EXPAND, ST_FETCH, ST_ROUND, ST_DONE} state_t;

    state_t             state_reg;
    logic [1:0]         ksz_reg;
    logic [255:0]       key_reg;
    logic               keys_ready_reg;
    logic               dec_reg;
    logic [127:0]       st_reg;
    logic [3:0]         rnd_reg;
    logic [1:0]         wsel_reg;
    logic [127:0]       rk_reg;
    logic [3:0]         nr;
    logic [RkAddrW-1:0] rd_addr;
    logic [31:0]        rd_data_reg;
    logic [31:0]        rk_mem [RoundKeyWords];
    logic               kx_start, kx_busy, kx_we;
    logic [RkAddrW-1:0] kx_addr;
    logic [31:0]        kx_data;
    logic [127:0]       rnd_out;
    logic [3:0]         key_round;

    assign nr = (ksz_reg == KS_128) ? 4'd10 : (ksz_reg == KS_192) ? 4'd12 : 4'd14;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksz_reg <= '0;
            key_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_SIZE: ksz_reg <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
                CFG_KEY_W0:   key_reg[255:192] <= cfg_data;
                CFG_KEY_W1:   key_reg[191:128] <= cfg_data;
                CFG_KEY_W2:   key_reg[127:64]  <= cfg_data;
                CFG_KEY_W3:   key_reg[63:0]    <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_key_expand u_kx (
        .aclk(aclk), .aresetn(aresetn), .start(kx_start), .key_size(ksz_reg),
        .key(key_reg), .busy(kx_busy), .wr_en(kx_we), .wr_addr(kx_addr), .wr_data(kx_data)
    );

    // Round-key store, one word read per cycle.
    always_ff @(posedge aclk) begin
        if (kx_we) rk_mem[kx_addr] <= kx_data;
        rd_data_reg <= rk_mem[rd_addr];
    end

    // Round the key fetch serves: encrypt counts up, decrypt counts down.
    assign key_round = dec_reg ? (nr - rnd_reg) : rnd_reg;
    assign rd_addr = RkAddrW'({key_round, wsel_reg});
    assign kx_start = (state_reg == ST_IDLE) && s_valid && !keys_ready_reg;

    aes_round_unit u_round (
        .state_in(st_reg), .round_key(rk_reg), .decrypt(dec_reg),
        .last(rnd_reg == nr), .state_out(rnd_out)
    );

    // Sequencer: fetch four key words, then apply one round.
    logic [2:0] fcnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index <= CFG_KEY_W3) keys_ready_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dec_reg  <= s_action;
                        st_reg   <= {s_data_hi, s_data_lo};
                        rnd_reg  <= '0;
                        wsel_reg <= '0;
                        fcnt_reg <= '0;
                        state_reg <= keys_ready_reg ? ST_FETCH : ST_EXPAND;
                    end
                end
                ST_EXPAND: begin
                    if (!kx_busy && !kx_start) begin
                        keys_ready_reg <= 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    wsel_reg <= wsel_reg + 2'd1;
                    fcnt_reg <= fcnt_reg + 3'd1;
                    if (fcnt_reg != 3'd0) begin
                        rk_reg <= {rk_reg[95:0], rd_data_reg};
                    end
                    if (fcnt_reg == 3'd4) state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (rnd_reg == 4'd0) begin
                        st_reg <= st_reg ^ rk_reg;
                    end else begin
                        st_reg <= rnd_out;
                    end
                    wsel_reg <= '0;
                    fcnt_reg <= '0;
                    if (rnd_reg == nr) begin
                        state_reg <= ST_DONE;
                    end else begin
                        rnd_reg   <= rnd_reg + 4'd1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_DONE: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_DONE);
    assign m_out_hi = st_reg[127:64];
    assign m_out_lo = st_reg[63:0];

    `AES_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "ready during result")
    `AES_ASSERT_NEXT(a_hold_res, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_hi), "result lost")
    `AES_ASSERT_IMPL(a_kx_idle, aclk, aresetn, kx_busy, state_reg == ST_EXPAND, "expansion outside expand")

endmodule

// File: design/aes_key_expand.sv
// -----------------------------------------------------------------------------
// AES key expansion
// Produces one round-key word per cycle and writes it into the round-key store.
// -----------------------------------------------------------------------------
module aes_key_expand (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [1:0]               key_size,
    input  logic [255:0]             key,
    output logic                     busy,
    output logic                     wr_en,
    output logic [aes_pkg::RkAddrW-1:0] wr_addr,
    output logic [31:0]              wr_data
);
    import aes_pkg::*;

    logic [3:0]         nk;
    logic [5:0]         total;
    logic [RkAddrW-1:0] idx_reg;
    logic [2:0]         pos_reg;
    logic [7:0]         rcon_reg;
    logic [31:0]        win_reg [8];
    logic               busy_reg;
    logic [31:0]        t;
    logic [31:0]        w_new;

    // Word count of the key and of the full schedule.
    always_comb begin
        unique case (key_size)
            KS_128:  nk = 4'd4;
            KS_192:  nk = 4'd6;
            default: nk = 4'd8;
        endcase
        total = 6'(4 * (int'(nk) + 7));
    end

    // Next schedule word from the sliding window of the last nk words.
    always_comb begin
        t = win_reg[3'(nk - 4'd1)];
        if (pos_reg == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && pos_reg == 3'd4) begin
            t = sub_word(t);
        end
        w_new = win_reg[0] ^ t;
    end

    // Sequencer: key words load first, then expanded words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && 6'(idx_reg) == total - 6'd1) begin
            busy_reg <= 1'b0;
        end
        if (start) begin
            for (int i = 0; i < 8; i++) begin
                win_reg[i] <= key[255 - 32*i -: 32];
            end
            idx_reg  <= '0;
            pos_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (busy_reg) begin
            idx_reg <= idx_reg + 1'b1;
            if (6'(idx_reg) >= 6'(nk) - 6'd1) begin
                for (int i = 0; i < 7; i++) begin
                    win_reg[i] <= (3'(i) == 3'(nk - 4'd1)) ? w_new : win_reg[i+1];
                end
                win_reg[7] <= w_new;
                pos_reg <= (pos_reg == 3'(nk - 4'd1)) ? 3'd0 : pos_reg + 3'd1;
                if (pos_reg == 3'd0) begin
                    rcon_reg <= xtime(rcon_reg);
                end
            end
        end
    end

    // Key words go out directly, later words from the generator.
    always_comb begin
        wr_en   = busy_reg;
        wr_addr = idx_reg;
        wr_data = (6'(idx_reg) < 6'(nk)) ? key[255 - 32*int'(idx_reg[2:0]) -: 32]
                                           : win_reg[3'(nk - 4'd1)];
    end
    assign busy = busy_reg;

endmodule

// File: design/aes_round_unit.sv
// -----------------------------------------------------------------------------
// AES round unit
// One encrypt or decrypt round of the 128-bit state, the final round when last is set.
// -----------------------------------------------------------------------------
module aes_round_unit (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         decrypt,
    input  logic         last,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [7:0] b  [16];
    logic [7:0] s  [16];
    logic [7:0] k  [16];
    logic [7:0] m  [16];
    logic [7:0] x2, x4, x8;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            b[i] = state_in[127 - 8*i -: 8];
            k[i] = round_key[127 - 8*i -: 8];
        end
        // Shift rows and byte substitution.
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (decrypt) begin
                    s[r + 4*c] = ISBOX[b[r + 4*((c + 4 - r) % 4)]];
                end else begin
                    s[r + 4*c] = SBOX[b[r + 4*((c + r) % 4)]];
                end
            end
        end
        // Encrypt mixes before the key, decrypt after it.
        if (decrypt) begin
            for (int i = 0; i < 16; i++) s[i] = s[i] ^ k[i];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                m[4*c + r] = 8'h00;
                for (int j = 0; j < 4; j++) begin
                    x2 = xtime(s[4*c + j]);
                    x4 = xtime(x2);
                    x8 = xtime(x4);
                    unique case ((j + 4 - r) % 4)
                        0: m[4*c + r] ^= decrypt ? (x8 ^ x4 ^ x2) : x2;
                        1: m[4*c + r] ^= decrypt ? (x8 ^ x2 ^ s[4*c+j]) : (x2 ^ s[4*c+j]);
                        2: m[4*c + r] ^= decrypt ? (x8 ^ x4 ^ s[4*c+j]) : s[4*c+j];
                        default: m[4*c + r] ^= decrypt ? (x8 ^ s[4*c+j]) : s[4*c+j];
                    endcase
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (last) begin
                state_out[127 - 8*i -: 8] = decrypt ? s[i] : (s[i] ^ k[i]);
            end else begin
                state_out[127 - 8*i -: 8] = decrypt ? m[i] : (m[i] ^ k[i]);
            end
        end
    end

endmodule
